// ----- sv/q4dq_pkg.sv -----
`default_nettype none

package q4dq_pkg;

  // Default widths of the datapath
  localparam int unsigned ActWidthDef = 16;
  localparam int unsigned AccWidthDef = 48;

  // Weight byte layout: two codes, low nibble first
  localparam int unsigned PackedW = 8;
  localparam int unsigned CodeW   = 4;

  // Control bits that travel down the pipeline with each item
  typedef struct packed {
    logic valid;
    logic upper;
    logic last;
  } q4dq_ctrl_t;

endpackage : q4dq_pkg

`default_nettype wire

// ----- sv/q4dq_if.sv -----
`default_nettype none

// Input channel: one pair of activations with their packed weight byte
interface q4dq_in_if #(
  parameter int unsigned ACT_WIDTH = q4dq_pkg::ActWidthDef
);
  import q4dq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [ACT_WIDTH-1:0] act_low;
  logic signed [ACT_WIDTH-1:0] act_high;
  logic        [PackedW-1:0]   packed_weights;
  logic signed [ACT_WIDTH-1:0] block_scale;
  logic signed [ACT_WIDTH-1:0] block_zero;
  logic                        upper_valid;
  logic                        row_last;

  modport source (
    output valid, act_low, act_high, packed_weights, block_scale, block_zero,
           upper_valid, row_last,
    input  ready
  );

  modport sink (
    input  valid, act_low, act_high, packed_weights, block_scale, block_zero,
           upper_valid, row_last,
    output ready
  );
endinterface : q4dq_in_if

// Output channel: one row result
interface q4dq_out_if #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] dot_sum;
  logic                        saturated;

  modport source (
    output valid, dot_sum, saturated,
    input  ready
  );

  modport sink (
    input  valid, dot_sum, saturated,
    output ready
  );
endinterface : q4dq_out_if

`default_nettype wire

// ----- sv/q4dq_lane.sv -----
`default_nettype none

// One dequantize-and-multiply lane: weight in the first stage, clipped
// product in the second.
module q4dq_lane #(
  parameter int unsigned ACT_WIDTH = q4dq_pkg::ActWidthDef,
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [ACT_WIDTH-1:0] act_i,
  input  wire logic [q4dq_pkg::CodeW-1:0]  code_i,
  input  wire logic signed [ACT_WIDTH-1:0] scale_i,
  input  wire logic signed [ACT_WIDTH-1:0] zero_i,
  output logic signed [ACC_WIDTH-1:0]      prod_o,
  output logic                             clip_o
);
  import q4dq_pkg::*;

  // zero + code*scale needs CodeW+1 extra bits plus one carry bit
  localparam int unsigned WeightW = ACT_WIDTH + CodeW + 2;
  localparam int unsigned ProdW   = ACT_WIDTH + WeightW;
  localparam int unsigned ExtW    = ((ProdW > ACC_WIDTH) ? ProdW : ACC_WIDTH) + 1;

  logic signed [WeightW-1:0]   code_scale;
  logic signed [WeightW-1:0]   weight_d, weight_q;
  logic signed [ACT_WIDTH-1:0] act_q;
  logic signed [ProdW-1:0]     prod;
  logic signed [ExtW-1:0]      prod_ext;
  logic signed [ExtW-1:0]      lim_ext;
  logic                        clip;
  logic signed [ACC_WIDTH-1:0] prod_d, prod_q;
  logic                        clip_d, clip_q;

  // Dequantize the weight code
  always_comb begin
    code_scale = WeightW'($signed({1'b0, code_i})) * WeightW'(scale_i);
    weight_d   = code_scale + WeightW'(zero_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
      act_q    <= act_i;
    end
  end

  // Multiply and clip to the accumulator range; a magnitude above the
  // positive limit flags, also when it lands exactly on the negative limit
  always_comb begin
    prod     = ProdW'(act_q) * ProdW'(weight_q);
    prod_ext = ExtW'(prod);
    lim_ext  = ExtW'($signed({1'b0, {(ACC_WIDTH-1){1'b1}}}));
    clip     = (prod_ext > lim_ext) || (prod_ext < -lim_ext);
    clip_d   = clip;
    if (clip) begin
      prod_d = prod_ext[ExtW-1] ? $signed({1'b1, {(ACC_WIDTH-1){1'b0}}})
                                : $signed({1'b0, {(ACC_WIDTH-1){1'b1}}});
    end else begin
      prod_d = prod_ext[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      clip_q <= clip_d;
    end
  end

  assign prod_o = prod_q;
  assign clip_o = clip_q;

endmodule : q4dq_lane

`default_nettype wire

// ----- sv/q4dq_merge.sv -----
`default_nettype none

// Merge stage: adds the low lane, then the high lane when ctrl upper is set,
// into the saturating accumulator and loads the output register at the end of a row.
module q4dq_merge #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire q4dq_pkg::q4dq_ctrl_t        ctrl_i,
  input  wire logic signed [ACC_WIDTH-1:0] prod_lo_i,
  input  wire logic                        clip_lo_i,
  input  wire logic signed [ACC_WIDTH-1:0] prod_hi_i,
  input  wire logic                        clip_hi_i,
  output logic                             out_valid_o,
  output logic signed [ACC_WIDTH-1:0]      dot_sum_o,
  output logic                             saturated_o
);
  import q4dq_pkg::*;

  // Saturating add, result is {overflow, sum}
  function automatic logic [ACC_WIDTH:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [ACC_WIDTH-1:0] b
  );
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      sat_add = s[ACC_WIDTH] ? {1'b1, 1'b1, {(ACC_WIDTH-1){1'b0}}}
                             : {1'b1, 1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sat_add = {1'b0, s[ACC_WIDTH-1:0]};
    end
  endfunction

  logic signed [ACC_WIDTH-1:0] acc_d, acc_q;
  logic                        ovf_d, ovf_q;
  logic [ACC_WIDTH:0]          add_lo, add_hi;
  logic signed [ACC_WIDTH-1:0] sum;
  logic                        ovf;
  logic                        out_valid_d, out_valid_q;
  logic signed [ACC_WIDTH-1:0] dot_sum_d, dot_sum_q;
  logic                        sat_d, sat_q;

  // Low element first, then the high element when it belongs to the row
  always_comb begin
    add_lo = sat_add(acc_q, prod_lo_i);
    add_hi = sat_add(add_lo[ACC_WIDTH-1:0], prod_hi_i);
    sum    = add_lo[ACC_WIDTH-1:0];
    ovf    = ovf_q | clip_lo_i | add_lo[ACC_WIDTH];
    if (ctrl_i.upper) begin
      sum = add_hi[ACC_WIDTH-1:0];
      ovf = ovf | clip_hi_i | add_hi[ACC_WIDTH];
    end
  end

  // Advance accumulator and output register together
  always_comb begin
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    dot_sum_d   = dot_sum_q;
    sat_d       = sat_q;
    if (en_i) begin
      out_valid_d = 1'b0;
      if (ctrl_i.valid) begin
        if (ctrl_i.last) begin
          out_valid_d = 1'b1;
          dot_sum_d   = sum;
          sat_d       = ovf;
          acc_d       = '0;
          ovf_d       = 1'b0;
        end else begin
          acc_d = sum;
          ovf_d = ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_sum_q <= dot_sum_d;
    sat_q     <= sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_sum_q;
  assign saturated_o = sat_q;

endmodule : q4dq_merge

`default_nettype wire

// ----- sv/q4_dequant_dot_product_core.sv -----
// Path: lane weight register, lane product register, merge output register.
// Throughput: one item per cycle; the two weight lanes and the merge adder
// run in lockstep, and the whole pipeline holds only while a result waits.
// Reset (rst_ni low, asynchronous): pipeline valid bits, the accumulator,
// the running overflow flag and the output valid are cleared.
`default_nettype none

module q4_dequant_dot_product_core #(
  parameter int unsigned ACT_WIDTH = q4dq_pkg::ActWidthDef,
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  q4dq_in_if.sink     in_i,
  q4dq_out_if.source  out_o
);
  import q4dq_pkg::*;

  logic                        en;
  logic                        out_valid;
  q4dq_ctrl_t                  s1_d, s1_q, s2_q;
  logic signed [ACC_WIDTH-1:0] prod_lo, prod_hi;
  logic                        clip_lo, clip_hi;
  logic signed [ACC_WIDTH-1:0] dot_sum;
  logic                        saturated;

  // Advance unless a finished result is still waiting
  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    s1_d.valid = in_i.valid;
    s1_d.upper = in_i.upper_valid;
    s1_d.last  = in_i.row_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  // Low-nibble lane
  q4dq_lane #(
    .ACT_WIDTH(ACT_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_lane_lo (
    .clk_i  (clk_i),
    .en_i   (en),
    .act_i  (ACT_WIDTH'(in_i.act_low)),
    .code_i (in_i.packed_weights[CodeW-1:0]),
    .scale_i(ACT_WIDTH'(in_i.block_scale)),
    .zero_i (ACT_WIDTH'(in_i.block_zero)),
    .prod_o (prod_lo),
    .clip_o (clip_lo)
  );

  // High-nibble lane
  q4dq_lane #(
    .ACT_WIDTH(ACT_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_lane_hi (
    .clk_i  (clk_i),
    .en_i   (en),
    .act_i  (ACT_WIDTH'(in_i.act_high)),
    .code_i (in_i.packed_weights[PackedW-1:CodeW]),
    .scale_i(ACT_WIDTH'(in_i.block_scale)),
    .zero_i (ACT_WIDTH'(in_i.block_zero)),
    .prod_o (prod_hi),
    .clip_o (clip_hi)
  );

  q4dq_merge #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctrl_i     (s2_q),
    .prod_lo_i  (prod_lo),
    .clip_lo_i  (clip_lo),
    .prod_hi_i  (prod_hi),
    .clip_hi_i  (clip_hi),
    .out_valid_o(out_valid),
    .dot_sum_o  (dot_sum),
    .saturated_o(saturated)
  );

  assign out_o.valid     = out_valid;
  assign out_o.dot_sum   = dot_sum;
  assign out_o.saturated = saturated;

endmodule : q4_dequant_dot_product_core

`default_nettype wire

// ----- sv/q4dq_checker.sv -----
`default_nettype none

module q4dq_checker #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 in_last_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [ACC_WIDTH-1:0] out_sum_i,
  input wire logic                 out_sat_i
);

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i) && $stable(out_sat_i))
    else $error("result changed or dropped before transfer");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A row end that meets no stall in the pipeline shows up as a valid result
  a_row_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) ##1 in_ready_i ##1 in_ready_i |=> out_valid_i)
    else $error("row end produced no result");

endmodule : q4dq_checker

bind q4_dequant_dot_product_core q4dq_checker #(
  .ACC_WIDTH(ACC_WIDTH)
) u_q4dq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.row_last),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_sum_i  (out_o.dot_sum),
  .out_sat_i  (out_o.saturated)
);

`default_nettype wire
